@@ hw/rtl/sds_pkg.sv @@
// Shared types, constants and helpers for the SCAN disk scheduler.
// No dependencies; imported by sds_cell, sds_chain and scan_disk_scheduler.
package sds_pkg;

  localparam int CYL_W             = 16;
  localparam int SEEK_W            = 17;
  localparam int MAX_REQUESTS_DEF  = 32;
  localparam logic [CYL_W-1:0] LAST_CYL_RESET = 16'd199;

  // One cell of a sorting or stacking row
  typedef struct packed {
    logic             valid;
    logic [CYL_W-1:0] value;
  } cell_data_t;

  // Per-cycle operation applied to a whole row of cells
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,    // sorted insert of the broadcast value
    CELL_SHIFT_LO,  // take the neighbor above (pop toward cell 0)
    CELL_SHIFT_HI   // take the neighbor below (push at cell 0)
  } cell_op_t;

  // Scheduler sequencing states
  typedef enum logic [2:0] {
    S_LOAD,
    S_SPLIT,
    S_FIRST,
    S_TURN,
    S_SECOND,
    S_EMPTY
  } state_t;

  function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] v,
                                                 input logic [CYL_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

@@ hw/rtl/sds_cell.sv @@
// One storage cell of a cylinder row: sorted insert, shift either way.
// Depends on sds_pkg.
module sds_cell
  import sds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_op_t         op,
  input  logic [CYL_W-1:0] new_val,
  input  cell_data_t       left,
  input  logic             left_ins,
  input  cell_data_t       right,
  output cell_data_t       data,
  output logic             ins
);

  logic             valid;
  logic [CYL_W-1:0] value;
  cell_data_t       data_next;

  assign data = '{valid: valid, value: value};

  // New value belongs at or below this cell; empty cells count as infinite
  assign ins = !valid || (new_val < value);

  // Select what this cell holds next
  always_comb begin
    data_next = data;
    unique case (op)
      CELL_HOLD:     data_next = data;
      CELL_INSERT: begin
        if (ins) begin
          data_next = left_ins ? left : cell_data_t'{valid: 1'b1, value: new_val};
        end
      end
      CELL_SHIFT_LO: data_next = right;
      CELL_SHIFT_HI: data_next = left;
      default:       data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= data_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= data_next.value;
  end

endmodule

@@ hw/rtl/sds_chain.sv @@
// A row of sds_cell instances that sorts, pops and pushes at cell 0.
// Depends on sds_pkg and sds_cell.
module sds_chain
  import sds_pkg::*;
#(
  parameter int DEPTH = MAX_REQUESTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_op_t         op,
  input  logic [CYL_W-1:0] new_val,
  input  cell_data_t       fill,
  output cell_data_t       first,
  output cell_data_t       second
);

  cell_data_t dat [DEPTH];
  logic       ins [DEPTH];

  // Wire each cell to its neighbors; cell 0 takes the fill item on a push
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_data_t left_d;
    cell_data_t right_d;
    logic       left_i;

    if (i == 0) begin : g_low
      assign left_d = fill;
      assign left_i = 1'b0;
    end else begin : g_mid
      assign left_d = dat[i-1];
      assign left_i = ins[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = dat[i+1];
    end

    sds_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (op),
      .new_val  (new_val),
      .left     (left_d),
      .left_ins (left_i),
      .right    (right_d),
      .data     (dat[i]),
      .ins      (ins[i])
    );
  end

  assign first  = dat[0];
  assign second = dat[1];

endmodule

@@ hw/rtl/scan_disk_scheduler.sv @@
// Loading: one item per cycle; each request is sorted into a row of cells on arrival.
// After the last item: each request at or below the head is moved to a stack, then one result
// per cycle (requests + turn point) while the consumer takes them; an empty first leg emits
// nothing before the turn point.
// No item is accepted from the last item until the final result enters the output register.
// Reset (synchronous): empty batch, empty rows, last_cylinder = 199, no result pending.
module scan_disk_scheduler
  import sds_pkg::*;
#(
  parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] cylinder
  input  logic        s_tlast,   // last
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] served_cylinder, [32:16] seek_total,
                                 // [33] dropped, [39:34] zero
  output logic        m_tuser,   // is_turn
  output logic        m_tlast,   // final_res
  // Configuration: last_cylinder
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   count;
  logic [CYL_W-1:0]   head;
  logic               head_loaded;
  logic               sweep_up;
  logic               overflowed;
  logic [CYL_W-1:0]   last_cyl;
  logic [CYL_W-1:0]   pos;
  logic [SEEK_W-1:0]  seek;

  logic [CYL_W-1:0]   out_cyl;
  logic [SEEK_W-1:0]  out_seek;
  logic               out_drop;

  cell_op_t           main_op, stk_op;
  cell_data_t         main_first, main_second, stk_first, stk_second;

  logic               accept, out_free, has_room;
  logic [CYL_W-1:0]   in_cyl, hc, m_val, s_val;
  logic               low_ready;
  logic               first_valid, first_more, second_valid, second_more;
  logic [CYL_W-1:0]   first_val, second_val, turn_val;

  logic               emit, emit_turn, emit_final, emit_zero, clear;
  logic [CYL_W-1:0]   emit_cyl;
  logic [SEEK_W-1:0]  emit_dist, emit_seek;

  // Sorted request row and the stack that reverses the low group
  sds_chain #(.DEPTH(MAX_REQUESTS)) u_main (
    .clk     (clk),
    .rst     (rst),
    .op      (main_op),
    .new_val (in_cyl),
    .fill    ('0),
    .first   (main_first),
    .second  (main_second)
  );

  sds_chain #(.DEPTH(MAX_REQUESTS)) u_stack (
    .clk     (clk),
    .rst     (rst),
    .op      (stk_op),
    .new_val (m_val),
    .fill    (cell_data_t'{valid: 1'b1, value: m_val}),
    .first   (stk_first),
    .second  (stk_second)
  );

  // Clamp everything to the current disk end
  assign in_cyl    = clamp_cyl(s_tdata, last_cyl);
  assign hc        = clamp_cyl(head, last_cyl);
  assign m_val     = clamp_cyl(main_first.value, last_cyl);
  assign s_val     = clamp_cyl(stk_first.value, last_cyl);
  assign low_ready = main_first.valid && (m_val <= hc);

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign has_room = count < CNT_W'(MAX_REQUESTS);

  // Sweep order picks which row feeds each leg
  assign first_valid  = sweep_up ? main_first.valid  : stk_first.valid;
  assign first_more   = sweep_up ? main_second.valid : stk_second.valid;
  assign first_val    = sweep_up ? m_val             : s_val;
  assign second_valid = sweep_up ? stk_first.valid   : main_first.valid;
  assign second_more  = sweep_up ? stk_second.valid  : main_second.valid;
  assign second_val   = sweep_up ? s_val             : m_val;
  assign turn_val     = sweep_up ? last_cyl          : '0;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (accept && s_tlast) begin
          state_next = head_loaded ? S_SPLIT : S_EMPTY;
        end
      end
      S_SPLIT: begin
        if (!low_ready) begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        if (!first_valid || (out_free && !first_more)) begin
          state_next = S_TURN;
        end
      end
      S_TURN: begin
        if (out_free) begin
          state_next = second_valid ? S_SECOND : S_LOAD;
        end
      end
      S_SECOND: begin
        if (!second_valid || (out_free && !second_more)) begin
          state_next = S_LOAD;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    main_op    = CELL_HOLD;
    stk_op     = CELL_HOLD;
    emit       = 1'b0;
    emit_cyl   = first_val;
    emit_turn  = 1'b0;
    emit_final = 1'b0;
    emit_zero  = 1'b0;
    clear      = 1'b0;
    unique case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (accept && head_loaded && has_room) begin
          main_op = CELL_INSERT;
        end
      end
      S_SPLIT: begin
        if (low_ready) begin
          main_op = CELL_SHIFT_LO;
          stk_op  = CELL_SHIFT_HI;
        end
      end
      S_FIRST: begin
        if (first_valid && out_free) begin
          emit     = 1'b1;
          emit_cyl = first_val;
          if (sweep_up) begin
            main_op = CELL_SHIFT_LO;
          end else begin
            stk_op = CELL_SHIFT_LO;
          end
        end
      end
      S_TURN: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_cyl   = turn_val;
          emit_turn  = 1'b1;
          emit_final = !second_valid;
          clear      = !second_valid;
        end
      end
      S_SECOND: begin
        if (!second_valid) begin
          clear = 1'b1;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_cyl   = second_val;
          emit_final = !second_more;
          clear      = !second_more;
          if (sweep_up) begin
            stk_op = CELL_SHIFT_LO;
          end else begin
            main_op = CELL_SHIFT_LO;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_cyl   = hc;
          emit_final = 1'b1;
          emit_zero  = 1'b1;
          clear      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Running seek: add the distance from the current position
  assign emit_dist = (emit_cyl >= pos) ? SEEK_W'(emit_cyl - pos) : SEEK_W'(pos - emit_cyl);
  assign emit_seek = emit_zero ? '0 : seek + emit_dist;

  // Batch control state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state       <= rst ? S_LOAD : state_next;
      count       <= '0;
      head        <= '0;
      head_loaded <= 1'b0;
      sweep_up    <= 1'b0;
      overflowed  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (!head_loaded) begin
          head        <= in_cyl;
          head_loaded <= 1'b1;
        end else if (has_room) begin
          count <= count + 1'b1;
          if (count == '0) begin
            sweep_up <= in_cyl > head;
          end
        end else begin
          overflowed <= 1'b1;
        end
      end
    end
  end

  // Disk end register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_cyl <= LAST_CYL_RESET;
    end else if (cfg_wr_en) begin
      last_cyl <= cfg_wr_data;
    end
  end

  // Head position and seek accumulator
  always_ff @(posedge clk) begin
    if (state == S_SPLIT) begin
      pos  <= hc;
      seek <= '0;
    end else if (emit) begin
      pos  <= emit_cyl;
      seek <= emit_seek;
    end
  end

  // Output register: refill whenever empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_cyl  <= emit_cyl;
      out_seek <= emit_seek;
      out_drop <= overflowed;
      m_tuser  <= emit_turn;
      m_tlast  <= emit_final;
    end
  end

  assign m_tdata = {6'b0, out_drop, out_seek, out_cyl};

`ifndef NO_ASSERTIONS
  a_main_sorted: assert property (@(posedge clk) disable iff (rst)
    main_second.valid |-> (main_first.valid && (main_first.value <= main_second.value)))
    else $error("request row lost its ascending order");

  a_stack_order: assert property (@(posedge clk) disable iff (rst)
    stk_second.valid |-> (stk_first.valid && (stk_first.value >= stk_second.value)))
    else $error("low-group stack is not descending from the top");

  a_load_empty_stack: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (!stk_first.valid && (main_first.valid == (count != '0))))
    else $error("rows disagree with the request count while loading");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_final) |=> ((state == S_LOAD) && (count == '0) && !head_loaded))
    else $error("batch not cleared after its final result");
`endif

endmodule

@@ tb/scan_disk_scheduler_test.sv @@
// Self-checking testbench for scan_disk_scheduler: directed batches, then random batches.
// Depends on sds_pkg and the scan_disk_scheduler RTL; predicts SCAN service order locally.
`timescale 1ns / 1ps

module scan_disk_scheduler_test;
  import sds_pkg::*;

  localparam int MAXR           = MAX_REQUESTS_DEF;
  localparam int RAND_ITEMS     = 180;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [15:0] cyl;
    logic        turn;
    logic [16:0] seek;
    logic        dropped;
    logic        fin;
  } visit_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [15:0] val;
    logic        lst;
    logic        typed;
    visit_t      want;
  } row_t;

  localparam visit_t NO_VISIT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  scan_disk_scheduler dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the scheduler state
  logic [15:0] req_store [MAXR];
  int          req_count  = 0;
  logic [15:0] head_pos   = '0;
  logic        head_known = 1'b0;
  logic        sweep_up   = 1'b0;
  logic        overflowed = 1'b0;
  logic [15:0] last_cyl   = LAST_CYL_RESET;

  visit_t plan_q[$];
  visit_t batch_q[$];
  row_t   script_q[$];

  int visit_errors = 0;
  int rand_items   = 0;
  int tx_idle_pct  = 16;
  int rx_idle_pct  = 71;
  int hold_left    = 0;
  bit hold_req     = 1'b0;

  function automatic logic [15:0] clip_cyl(input logic [15:0] v);
    return (v > last_cyl) ? last_cyl : v;
  endfunction

  // Move the head to a cylinder, add the travel and record the visit
  task automatic step_to(input logic [15:0] target, input logic turn,
                         inout int seek, inout logic [15:0] pos);
    seek += (target > pos) ? int'(target - pos) : int'(pos - target);
    pos = target;
    batch_q.push_back(visit_t'{target, turn, seek[16:0], overflowed, 1'b0});
  endtask

  // Absorb one item; on a last item, append the whole service order to plan_q
  task automatic plan_service(input logic [15:0] cyl_in, input logic lst);
    logic [15:0] c, hd, v, pos;
    logic [15:0] srt [MAXR];
    int n, split, j, seek;
    visit_t vis;
    c = clip_cyl(cyl_in);
    if (!head_known) begin
      head_pos = c;
      head_known = 1'b1;
    end else if (req_count < MAXR) begin
      if (req_count == 0) sweep_up = (c > head_pos);
      req_store[req_count] = c;
      req_count++;
    end else begin
      overflowed = 1'b1;
    end
    if (!lst) return;

    hd = clip_cyl(head_pos);
    n = req_count;
    batch_q.delete();
    if (n == 0) begin
      batch_q.push_back(visit_t'{hd, 1'b0, 17'd0, overflowed, 1'b0});
    end else begin
      // Re-clip against the current limit and sort ascending
      for (int i = 0; i < n; i++) begin
        v = clip_cyl(req_store[i]);
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      split = n;
      for (int i = n - 1; i >= 0; i--) begin
        if (srt[i] > hd) split = i;
      end
      seek = 0;
      pos = hd;
      if (sweep_up) begin
        for (int i = split; i < n; i++) step_to(srt[i], 1'b0, seek, pos);
        step_to(last_cyl, 1'b1, seek, pos);
        for (int i = split; i > 0; i--) step_to(srt[i-1], 1'b0, seek, pos);
      end else begin
        for (int i = split; i > 0; i--) step_to(srt[i-1], 1'b0, seek, pos);
        step_to(16'd0, 1'b1, seek, pos);
        for (int i = split; i < n; i++) step_to(srt[i], 1'b0, seek, pos);
      end
    end
    for (int i = 0; i < batch_q.size(); i++) begin
      vis = batch_q[i];
      vis.fin = (i == batch_q.size() - 1);
      plan_q.push_back(vis);
    end
    req_count = 0;
    head_pos = '0;
    head_known = 1'b0;
    sweep_up = 1'b0;
    overflowed = 1'b0;
  endtask

  // Offer one item; predict once it is accepted
  task automatic send_item(input logic [15:0] cyl, input logic lst,
                           input logic typed, input visit_t want);
    int before_n;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cyl;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    before_n = plan_q.size();
    plan_service(cyl, lst);
    if (typed) begin
      while (plan_q.size() > before_n) plan_q.delete(plan_q.size() - 1);
      plan_q.push_back(want);
    end
  endtask

  // Drain all results, let the block settle, then write last_cylinder
  task automatic set_last_cyl(input logic [15:0] v);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    last_cyl = v;
  endtask

  function automatic logic [15:0] pick_cyl();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom_range(0, int'(last_cyl)));
      2:       return 16'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'd0;
          1:       return last_cyl;
          2:       return 16'hFFFF;
          default: return last_cyl + 16'd1;
        endcase
      end
    endcase
  endfunction

  // One batch: head item, then n_req requests, last on the final item
  task automatic run_batch(input int n_req);
    send_item(pick_cyl(), n_req == 0, 1'b0, NO_VISIT);
    for (int i = 1; i <= n_req; i++) send_item(pick_cyl(), i == n_req, 1'b0, NO_VISIT);
    rand_items += n_req + 1;
  endtask

  task automatic script(input row_kind_e kind, input logic [15:0] val, input logic lst,
                        input logic typed, input visit_t want);
    script_q.push_back('{kind, val, lst, typed, want});
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest planned visit
  always @(posedge clk) begin
    visit_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = visit_t'{m_tdata[15:0], m_tuser, m_tdata[32:16], m_tdata[33], m_tlast};
      if (plan_q.size() == 0) begin
        visit_errors++;
        if (visit_errors <= REPORT_LIMIT)
          $display("unexpected result: cyl %0d turn %0b seek %0d drop %0b last %0b",
                   got.cyl, got.turn, got.seek, got.dropped, got.fin);
      end else begin
        want = plan_q.pop_front();
        if (got.cyl !== want.cyl || got.turn !== want.turn || got.seek !== want.seek ||
            got.dropped !== want.dropped || got.fin !== want.fin) begin
          visit_errors++;
          if (visit_errors <= REPORT_LIMIT)
            $display("mismatch: exp cyl %0d turn %0b seek %0d drop %0b last %0b / got cyl %0d turn %0b seek %0d drop %0b last %0b",
                     want.cyl, want.turn, want.seek, want.dropped, want.fin,
                     got.cyl, got.turn, got.seek, got.dropped, got.fin);
        end
      end
    end
  end

  // Stop a run in which nothing moves for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int n_req;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed batches: empty batches, equal-to-head, no request above, limit extremes
    script(ROW_ITEM, 16'd0,     1'b1, 1'b1, visit_t'{16'd0, 1'b0, 17'd0, 1'b0, 1'b1});
    script(ROW_ITEM, 16'hFFFF,  1'b1, 1'b1, visit_t'{16'd199, 1'b0, 17'd0, 1'b0, 1'b1});
    script(ROW_ITEM, 16'd100,   1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd150,   1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd50,    1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd100,   1'b1, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd100,   1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd100,   1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd199,   1'b1, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd150,   1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd20,    1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd60,    1'b1, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd10,    1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'hFFFF,  1'b1, 1'b0, NO_VISIT);
    script(ROW_CFG,  16'hFFFF,  1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'hFFFF,  1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd0,     1'b1, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'hFFFF,  1'b1, 1'b1, visit_t'{16'hFFFF, 1'b0, 17'd0, 1'b0, 1'b1});
    script(ROW_CFG,  16'd0,     1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd5,     1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd7,     1'b1, 1'b0, NO_VISIT);
    script(ROW_CFG,  16'd1,     1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd40000, 1'b1, 1'b1, visit_t'{16'd1, 1'b0, 17'd0, 1'b0, 1'b1});
    script(ROW_CFG,  16'd1000,  1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd900,   1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd950,   1'b0, 1'b0, NO_VISIT);
    // Shrink the limit in the middle of a batch
    script(ROW_CFG,  16'd199,   1'b0, 1'b0, NO_VISIT);
    script(ROW_ITEM, 16'd10,    1'b1, 1'b0, NO_VISIT);

    foreach (script_q[i]) begin
      if (script_q[i].kind == ROW_CFG) set_last_cyl(script_q[i].val);
      else send_item(script_q[i].val, script_q[i].lst, script_q[i].typed, script_q[i].want);
    end

    // Random batches in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 71 : 0;
      rx_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 16 : 0;
      if (ph == 2) begin
        // Hold the output off and overfill the store, last on a dropped request
        @(posedge clk);
        hold_req = 1'b1;
        run_batch(MAXR + 2);
      end
      while (rand_items < (ph + 1) * RAND_ITEMS / 3) begin
        if ($urandom_range(0, 5) == 0) begin
          case ($urandom_range(0, 5))
            0:       set_last_cyl(16'd0);
            1:       set_last_cyl(16'd1);
            2:       set_last_cyl(16'hFFFF);
            3:       set_last_cyl(LAST_CYL_RESET);
            default: set_last_cyl(16'($urandom_range(1, 3000)));
          endcase
        end
        n_req = ($urandom_range(0, 7) == 0) ? $urandom_range(MAXR - 4, MAXR + 4)
                                            : $urandom_range(0, 10);
        run_batch(n_req);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    repeat (4 * MAXR) @(posedge clk);
    if (visit_errors == 0 && plan_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sds_pkg.sv
hw/rtl/sds_cell.sv
hw/rtl/sds_chain.sv
hw/rtl/scan_disk_scheduler.sv
tb/scan_disk_scheduler_test.sv
